@@ rtl/qsu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_pkg - shared types for the quoted string unescape parser
// Result beat layout, queue entry layout and queue sizing.
// ----------------------------------------------------------------------------
package qsu_pkg;

   // Entries in the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One decoded result, without the last flag (back end adds it).
   typedef struct packed {
      logic [7:0] data;
      logic       mark;
      logic       cause;
   } result_type;

   // All results caused by one input byte: one or two.
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

   // Front -> queue write.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   // Queue -> back head of line.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage
`default_nettype wire

@@ rtl/qsu_chan_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_chan_if - request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface qsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface qsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_end_marker;
   logic       end_cause;
   logic       last_of_run;

   modport source (output valid, output out_byte, output is_end_marker,
                   output end_cause, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input is_end_marker,
                   input end_cause, input last_of_run, output ready);
endinterface
`default_nettype wire

@@ rtl/qsu_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_front - parse state machine
// Takes one byte per beat, updates the parse mode and writes the results
// that the byte causes as one queue entry.
// ----------------------------------------------------------------------------
module qsu_front (
   input  wire logic         clock,
   input  wire logic         reset,
   qsu_req_if.sink           req,
   input  wire logic         queue_full,
   output qsu_pkg::push_type push
);

   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef enum logic [2:0] {
      MODE_OUT = 3'd0,
      MODE_IN  = 3'd1,
      MODE_ESC = 3'd2,
      MODE_CR  = 3'd3,
      MODE_OCT = 3'd4
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [5:0]  oct_ff, oct_in;      // two digits at most are held
   logic [1:0]  cnt_ff, cnt_in;
   logic        fire;
   logic [7:0]  b;
   logic [2:0]  digit;
   logic        b_ws, b_oct, b_quote, b_bslash;
   mode_type    q_mode;             // mode after a plain in-quote byte
   logic        has;
   qsu_pkg::entry_type entry;

   assign req.ready = !queue_full;
   assign fire      = req.valid && !queue_full;
   assign b         = req.in_byte;
   assign digit     = b[2:0];
   assign b_ws      = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   assign b_oct     = (b >= CH_ZERO) && (b <= CH_SEVEN);
   assign b_quote   = (b == CH_QUOTE);
   assign b_bslash  = (b == CH_BSLASH);
   assign q_mode    = b_quote ? MODE_OUT : (b_bslash ? MODE_ESC : MODE_IN);

   always_comb begin
      mode_in = mode_ff;
      oct_in  = oct_ff;
      cnt_in  = cnt_ff;
      has     = 1'b0;
      entry   = '0;
      if (req.end_of_input) begin
         has = 1'b1;
         if (mode_ff == MODE_OCT) begin
            entry.two          = 1'b1;
            entry.first.data   = {2'b00, oct_ff};
            entry.second.mark  = 1'b1;
            entry.second.cause = 1'b1;
         end else begin
            entry.first.mark  = 1'b1;
            entry.first.cause = 1'b1;
         end
         mode_in = MODE_OUT;
         oct_in  = '0;
         cnt_in  = '0;
      end else begin
         case (mode_ff)
            MODE_IN: begin
               mode_in          = q_mode;
               has              = !b_quote && !b_bslash;
               entry.first.data = b;
            end
            MODE_ESC: begin
               mode_in = MODE_IN;
               has     = 1'b1;
               if (b == CH_N) begin
                  entry.first.data = CH_LF;
               end else if (b == CH_R) begin
                  entry.first.data = CH_CR;
               end else if (b == CH_T) begin
                  entry.first.data = CH_TAB;
               end else if (b == CH_CR) begin
                  has     = 1'b0;
                  mode_in = MODE_CR;
               end else if (b == CH_LF) begin
                  has = 1'b0;
               end else if (b_oct) begin
                  has     = 1'b0;
                  mode_in = MODE_OCT;
                  oct_in  = {3'b000, digit};
                  cnt_in  = 2'd1;
               end else begin
                  entry.first.data = b;
               end
            end
            MODE_CR: begin
               if (b == CH_LF) begin
                  mode_in = MODE_IN;
               end else begin
                  mode_in          = q_mode;
                  has              = !b_quote && !b_bslash;
                  entry.first.data = b;
               end
            end
            MODE_OCT: begin
               if (b_oct) begin
                  if (cnt_ff == 2'd2) begin
                     // third digit: value complete
                     has              = 1'b1;
                     entry.first.data = {oct_ff[4:0], digit};
                     mode_in          = MODE_IN;
                     oct_in           = '0;
                     cnt_in           = '0;
                  end else begin
                     oct_in = {oct_ff[2:0], digit};
                     cnt_in = 2'd2;
                  end
               end else begin
                  // value first, then the byte as an in-quote byte
                  has               = 1'b1;
                  entry.first.data  = {2'b00, oct_ff};
                  entry.two         = !b_quote && !b_bslash;
                  entry.second.data = b;
                  mode_in           = q_mode;
                  oct_in            = '0;
                  cnt_in            = '0;
               end
            end
            default: begin
               if (b_ws) begin
                  mode_in = MODE_OUT;
               end else if (b_quote) begin
                  mode_in = MODE_IN;
               end else begin
                  has              = 1'b1;
                  entry.first.data = b;
                  entry.first.mark = 1'b1;
                  mode_in          = MODE_OUT;
                  oct_in           = '0;
                  cnt_in           = '0;
               end
            end
         endcase
      end
   end

   assign push.valid = fire && has;
   assign push.entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OUT;
         oct_ff  <= '0;
         cnt_ff  <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         oct_ff  <= oct_in;
         cnt_ff  <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_cnt_only_in_octal: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> (mode_ff == MODE_OCT))
      else $error("octal digit count set outside octal mode");
   a_eoi_restarts: assert property (@(posedge clock) disable iff (reset)
      (fire && req.end_of_input) |=> (mode_ff == MODE_OUT && cnt_ff == 2'd0))
      else $error("end of input did not return to start state");
`endif

endmodule
`default_nettype wire

@@ rtl/qsu_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_queue - entry queue between front and back
// Small register FIFO; push and pop may occur in the same cycle.
// ----------------------------------------------------------------------------
module qsu_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire qsu_pkg::push_type push,
   input  wire logic              pop,
   output qsu_pkg::head_type      head,
   output logic                   full
);

   qsu_pkg::entry_type                 mem_ff [qsu_pkg::QUEUE_DEPTH];
   logic [qsu_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [qsu_pkg::QUEUE_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                               do_pop;

   localparam logic [qsu_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      qsu_pkg::QUEUE_CNT_W'(qsu_pkg::QUEUE_DEPTH);
   localparam logic [qsu_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      qsu_pkg::QUEUE_PTR_W'(qsu_pkg::QUEUE_DEPTH - 1);

   assign full       = (cnt_ff == CNT_FULL);
   assign head.valid = (cnt_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (push.valid && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !push.valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head.valid))
      else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

@@ rtl/qsu_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_back - result sequencer
// Pops queue entries, splits two-result entries into two beats and holds
// the response in an output register.
// ----------------------------------------------------------------------------
module qsu_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire qsu_pkg::head_type head,
   output logic                   pop,
   qsu_rsp_if.source              rsp
);

   logic                 out_valid_ff;
   qsu_pkg::result_type  out_ff;
   logic                 out_last_ff;
   logic                 pend_valid_ff;
   qsu_pkg::result_type  pend_ff;
   logic                 load;

   assign load = !out_valid_ff || rsp.ready;
   assign pop  = load && !pend_valid_ff && head.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (load) begin
         if (pend_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_ff        <= pend_ff;
            out_last_ff   <= 1'b1;
            pend_valid_ff <= 1'b0;
         end else if (head.valid) begin
            out_valid_ff  <= 1'b1;
            out_ff        <= head.entry.first;
            out_last_ff   <= !head.entry.two;
            pend_valid_ff <= head.entry.two;
            pend_ff       <= head.entry.second;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.out_byte      = out_ff.data;
   assign rsp.is_end_marker = out_ff.mark;
   assign rsp.end_cause     = out_ff.cause;
   assign rsp.last_of_run   = out_last_ff;

`ifndef SYNTHESIS
   a_pend_behind_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (out_valid_ff && !out_last_ff))
      else $error("second result pending without a first one on the output");
`endif

endmodule
`default_nettype wire

@@ rtl/quoted_string_unescape_parser_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_string_unescape_parser_top - C-style quoted string decoder
// Decodes adjacent double-quoted strings from a byte stream, with escapes.
// ----------------------------------------------------------------------------
// Usage:
//  - req_bus carries one raw byte per beat plus end_of_input. Each beat
//    makes zero, one or two rsp_bus beats: decoded characters, and an end
//    marker (is_end_marker=1) when an unquoted non-space byte or end of
//    input finishes the string. last_of_run flags the final beat per input.
//  - Path: an accepted byte's results are written into the queue as one
//    entry, then moved into the output register once it is free.
//  - Throughput: one input beat per cycle. A byte with two results (octal
//    escape ended by another byte, or end of input during octal) gives two
//    output beats; the 4-entry queue between the parser and the output
//    sequencer absorbs these, and req_bus.ready drops only when it is full.
//  - rsp_bus stall: the output register holds its beat; the parser keeps
//    taking bytes until the queue fills.
//  - Reset (synchronous): parser back to "outside quotes", queue and output
//    emptied. No configuration.
// ----------------------------------------------------------------------------
module quoted_string_unescape_parser_top (
   input  wire logic clock,
   input  wire logic reset,
   qsu_req_if.sink   req_bus,
   qsu_rsp_if.source rsp_bus
);

   qsu_pkg::push_type push;   // front -> queue
   qsu_pkg::head_type head;   // queue -> back
   logic              queue_full;
   logic              pop;

   // Front: parse mode machine, one byte a cycle while the queue is not full.
   qsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .queue_full (queue_full),
      .push       (push)
   );

   // Queue decouples parsing from result delivery.
   qsu_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   // Back: one result beat a cycle into the output register unless rsp_bus stalls.
   qsu_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule
`default_nettype wire

@@ bench/tb_quoted_string_unescape_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quoted_string_unescape_parser_top - unescape parser self-checking bench
// Drives raw text bytes with random gaps, runs its own parser to predict each
// decoded character and end marker, and checks every response beat in order.
// ----------------------------------------------------------------------------
module tb_quoted_string_unescape_parser_top;

   // Bytes the parser treats specially.
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_SEMI   = 8'h3B;   // stand-in for a banned byte

   localparam logic [7:0] WS_BYTES [6]    = '{8'h20, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR};
   localparam logic [7:0] ESC_LETTERS [3] = '{CH_N, CH_R, CH_T};

   // Request beat: bit 8 is end_of_input.
   localparam logic [8:0] EOI_ITEM = 9'h100;

   localparam int ITEM_TARGET    = 1780;
   localparam int PHASE_ITEMS    = 250;
   localparam int HOLD_AT_ITEM   = 500;
   localparam int DRAIN_AT_ITEM  = 1100;
   localparam int LONG_HOLD      = 64;
   localparam int TAIL_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [2:0] {
      PM_OUT = 3'd0,   // outside quotes, skipping whitespace
      PM_IN  = 3'd1,   // inside quotes
      PM_ESC = 3'd2,   // after a backslash
      PM_CR  = 3'd3,   // after backslash CR
      PM_OCT = 3'd4    // collecting octal digits
   } parse_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       mark;
      logic       cause;
      logic       last;
   } rsp_beat_type;

   // Directed opening: empty string at end of input, unquoted 0x00 and 0x80,
   // 0xFF inside quotes, \n, backslash CR then a plain byte, backslash CR LF,
   // backslash LF, three-digit octal overflowing 8 bits, octal cut short by a
   // byte, end of input in octal and right after a backslash.
   localparam logic [8:0] DIRECTED [28] = '{
      EOI_ITEM,
      {1'b0, 8'h00},
      {1'b0, CH_QUOTE},
      {1'b0, 8'hFF},
      {1'b0, CH_BSLASH}, {1'b0, CH_N},
      {1'b0, CH_BSLASH}, {1'b0, CH_CR}, {1'b0, 8'h42},
      {1'b0, CH_BSLASH}, {1'b0, CH_CR}, {1'b0, CH_LF},
      {1'b0, CH_BSLASH}, {1'b0, CH_LF},
      {1'b0, CH_BSLASH}, {1'b0, CH_ZERO + 8'd7}, {1'b0, CH_ZERO + 8'd7},
      {1'b0, CH_ZERO + 8'd7},
      {1'b0, CH_BSLASH}, {1'b0, CH_ZERO + 8'd5}, {1'b0, 8'h78},
      {1'b0, CH_BSLASH}, {1'b0, CH_ZERO + 8'd2}, EOI_ITEM,
      {1'b0, CH_QUOTE}, {1'b0, CH_BSLASH}, EOI_ITEM,
      {1'b0, 8'h80}
   };

   function automatic logic is_space(input logic [7:0] b);
      return b == 8'h20 || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic logic is_octal(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_ZERO + 8'd7;
   endfunction

   // -------------------------------------------------------------------------
   // Parser model and expected-beat store
   // -------------------------------------------------------------------------
   class unescape_scoreboard;
      parse_mode_type mode;
      logic [8:0]     oct_value;
      logic [1:0]     oct_digits;
      rsp_beat_type   expected_q[$];
      rsp_beat_type   run_q[$];     // beats caused by the byte being decoded
      int             mismatches;

      function new();
         mode       = PM_OUT;
         oct_value  = '0;
         oct_digits = '0;
         mismatches = 0;
      endfunction

      function void emit(input logic [7:0] data, input logic mark, input logic cause);
         rsp_beat_type r;
         r.data  = data;
         r.mark  = mark;
         r.cause = cause;
         r.last  = 1'b0;
         if (run_q.size() < 2) run_q.push_back(r);
      endfunction

      function void quoted_byte(input logic [7:0] b);
         if (b == CH_QUOTE) mode = PM_OUT;
         else if (b == CH_BSLASH) mode = PM_ESC;
         else emit(b, 1'b0, 1'b0);
      endfunction

      function void flush_octal();
         emit(oct_value[7:0], 1'b0, 1'b0);
         mode       = PM_IN;
         oct_value  = '0;
         oct_digits = '0;
      endfunction

      function void note_byte(input logic [7:0] b, input logic eoi);
         rsp_beat_type tail;
         run_q.delete();
         if (eoi) begin
            if (mode == PM_OCT) emit(oct_value[7:0], 1'b0, 1'b0);
            emit(8'h00, 1'b1, 1'b1);
            mode       = PM_OUT;
            oct_value  = '0;
            oct_digits = '0;
         end else begin
            case (mode)
               PM_IN: quoted_byte(b);
               PM_ESC: begin
                  mode = PM_IN;
                  if (b == CH_N) emit(CH_LF, 1'b0, 1'b0);
                  else if (b == CH_R) emit(CH_CR, 1'b0, 1'b0);
                  else if (b == CH_T) emit(CH_TAB, 1'b0, 1'b0);
                  else if (b == CH_CR) mode = PM_CR;
                  else if (b == CH_LF) mode = PM_IN;   // line continuation
                  else if (is_octal(b)) begin
                     mode       = PM_OCT;
                     oct_value  = {6'd0, 3'(b - CH_ZERO)};
                     oct_digits = 2'd1;
                  end else emit(b, 1'b0, 1'b0);
               end
               PM_CR: begin
                  mode = PM_IN;
                  if (b != CH_LF) quoted_byte(b);
               end
               PM_OCT: begin
                  if (is_octal(b)) begin
                     oct_value  = {oct_value[5:0], 3'(b - CH_ZERO)};
                     oct_digits = oct_digits + 2'd1;
                     if (oct_digits == 2'd3 || oct_digits == 2'd0) flush_octal();
                  end else begin
                     flush_octal();
                     quoted_byte(b);
                  end
               end
               default: begin
                  if (is_space(b)) mode = PM_OUT;
                  else if (b == CH_QUOTE) mode = PM_IN;
                  else begin
                     emit(b, 1'b1, 1'b0);
                     mode       = PM_OUT;
                     oct_value  = '0;
                     oct_digits = '0;
                  end
               end
            endcase
         end
         if (run_q.size() > 0) begin
            tail      = run_q.pop_back();
            tail.last = 1'b1;
            run_q.push_back(tail);
         end
         foreach (run_q[i]) expected_q.push_back(run_q[i]);
      endfunction

      function void check_beat(input rsp_beat_type got);
         rsp_beat_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected beat: byte=%h mark=%b cause=%b last=%b",
                        got.data, got.mark, got.cause, got.last);
         end else begin
            want = expected_q.pop_front();
            if (got.data !== want.data || got.mark !== want.mark ||
                got.cause !== want.cause || got.last !== want.last) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("beat mismatch: expected byte=%h mark=%b cause=%b last=%b,",
                           want.data, want.mark, want.cause, want.last,
                           " got byte=%h mark=%b cause=%b last=%b",
                           got.data, got.mark, got.cause, got.last);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;

   qsu_req_if req_bus();
   qsu_rsp_if rsp_bus();

   quoted_string_unescape_parser_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   unescape_scoreboard sb = new();

   int items_sent   = 0;
   int tx_idle_max  = 4;
   int rx_idle_max  = 4;
   bit hold_rx      = 1'b0;   // asks the response side for one long stall
   int idle_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // One request beat: random gap (valid low), then offer until ready.
   // valid stays high on return so back-to-back beats never glitch it.
   task automatic send_item(input logic [7:0] b, input logic eoi);
      int gap;
      gap = $urandom_range(0, tx_idle_max);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.in_byte      <= b;
      req_bus.end_of_input <= eoi;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_byte(b, eoi);
      items_sent++;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int         n_str;
      int         n_piece;
      int         kind;
      int         next_phase;
      bit         hold_done;
      bit         drain_done;
      logic [7:0] b;

      next_phase = PHASE_ITEMS;
      hold_done  = 1'b0;
      drain_done = 1'b0;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.in_byte      <= 8'h00;
      req_bus.end_of_input <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_item(DIRECTED[i][7:0], DIRECTED[i][8]);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 85) begin
            // Well-formed record: ws, one to three quoted strings joined by
            // ws, then a terminator (unquoted byte or end of input).
            repeat ($urandom_range(0, 2)) send_item(WS_BYTES[$urandom_range(0, 5)], 1'b0);
            n_str = $urandom_range(1, 3);
            for (int s = 0; s < n_str; s++) begin
               if (s != 0)
                  repeat ($urandom_range(0, 2))
                     send_item(WS_BYTES[$urandom_range(0, 5)], 1'b0);
               send_item(CH_QUOTE, 1'b0);
               n_piece = $urandom_range(0, 6);
               for (int p = 0; p < n_piece; p++) begin
                  kind = $urandom_range(0, 9);
                  case (kind)
                     3: begin       // \n \r \t
                        send_item(CH_BSLASH, 1'b0);
                        send_item(ESC_LETTERS[$urandom_range(0, 2)], 1'b0);
                     end
                     4: begin       // backslash CR, LF or some other byte after
                        send_item(CH_BSLASH, 1'b0);
                        send_item(CH_CR, 1'b0);
                        if ($urandom_range(0, 1) == 0) send_item(CH_LF, 1'b0);
                        else send_item(8'($urandom_range(0, 255)), 1'b0);
                     end
                     5: begin       // backslash LF
                        send_item(CH_BSLASH, 1'b0);
                        send_item(CH_LF, 1'b0);
                     end
                     6, 7: begin    // octal, one to three digits
                        send_item(CH_BSLASH, 1'b0);
                        repeat ($urandom_range(1, 3))
                           send_item(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
                     end
                     8: begin       // any escaped byte
                        send_item(CH_BSLASH, 1'b0);
                        send_item(8'($urandom_range(0, 255)), 1'b0);
                     end
                     default: begin // plain character
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_QUOTE || b == CH_BSLASH) b = CH_SEMI;
                        send_item(b, 1'b0);
                     end
                  endcase
               end
               // now and then leave the string open: terminator lands inside
               if ($urandom_range(0, 9) != 0) send_item(CH_QUOTE, 1'b0);
            end
            if ($urandom_range(0, 3) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
            else begin
               b = 8'($urandom_range(0, 255));
               if (is_space(b) || b == CH_QUOTE) b = CH_SEMI;
               send_item(b, 1'b0);
            end
         end else begin
            // noise: raw bytes, end of input sprinkled in
            repeat ($urandom_range(1, 8))
               send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end

         // new gap profile per phase; zero max gives stretches with no idling
         if (items_sent >= next_phase) begin
            tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
            rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
            next_phase += PHASE_ITEMS;
         end

         // long response stall while requests keep coming: queue fills up
         if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            hold_rx   = 1'b1;
            hold_done = 1'b1;
         end

         // sender goes quiet until the block has drained completely
         if (!drain_done && items_sent >= DRAIN_AT_ITEM) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
            drain_done = 1'b1;
         end
      end

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: random ready gaps, plus the one long hold
   // -------------------------------------------------------------------------
   initial begin : rsp_sink
      int gap;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rx) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rx = 1'b0;
         end
         gap = $urandom_range(0, rx_idle_max);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Check every accepted response beat against the oldest expectation.
   always @(posedge clock) begin : rsp_monitor
      rsp_beat_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.data  = rsp_bus.out_byte;
         got.mark  = rsp_bus.is_end_marker;
         got.cause = rsp_bus.end_cause;
         got.last  = rsp_bus.last_of_run;
         sb.check_beat(got);
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

@@ sim.f @@
rtl/qsu_pkg.sv
rtl/qsu_chan_if.sv
rtl/qsu_front.sv
rtl/qsu_queue.sv
rtl/qsu_back.sv
rtl/quoted_string_unescape_parser_top.sv
bench/tb_quoted_string_unescape_parser_top.sv
